// ----- rtl/core/u8tx_pkg.sv -----
// ----------------------------------------------------------------------------
// u8tx_pkg
// Shared types and constants for the UTF-8 to UTF-16 / UTF-32 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8tx_pkg;

  localparam int UNIT_W      = 21;
  localparam int COUNT_WIDTH = 24;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // lead byte class boundaries
  localparam logic [7:0] LEAD_2B_MAX = 8'hDF;
  localparam logic [7:0] LEAD_3B_MAX = 8'hEF;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  localparam logic [UNIT_W-1:0] SUPP_BASE    = 21'h010000;
  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 21'h00D800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 21'h00DC00;

  localparam logic MODE_UTF16 = 1'b0;

  // one queue entry holds what a single byte releases:
  // an optional flushed partial point, then optionally a point or a terminator
  typedef struct packed {
    logic              has_a;
    logic [UNIT_W-1:0] pt_a;
    logic              has_b;
    logic              b_term;
    logic [UNIT_W-1:0] pt_b;
  } u8tx_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/u8tx_front.sv -----
// ----------------------------------------------------------------------------
// u8tx_front
// Byte decoder: tracks the open code point and pushes released events.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tx_front
  import u8tx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        q_full,
  output logic             push,
  output u8tx_entry_t      push_entry
);

  logic [UNIT_W-1:0] partial;
  logic [UNIT_W-1:0] partial_next;
  logic [1:0]        expect_cnt;
  logic [1:0]        expect_cnt_next;
  logic              accept;
  logic              open_seq;
  logic [1:0]        dec_cnt;
  logic [UNIT_W-1:0] cont_bits;
  logic [UNIT_W-1:0] merged;
  u8tx_entry_t       ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign open_seq = (expect_cnt != 2'd0);
  assign dec_cnt  = expect_cnt - 2'd1;

  always_comb begin
    cont_bits = '0;
    case (dec_cnt)
      2'd0:    cont_bits = {15'd0, in_byte[5:0]};
      2'd1:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
      default: cont_bits = {3'd0, in_byte[5:0], 12'd0};
    endcase
  end

  assign merged = partial | cont_bits;

  always_comb begin
    ent             = '0;
    partial_next    = partial;
    expect_cnt_next = expect_cnt;
    if (in_byte == 8'd0) begin
      ent.has_a       = open_seq;
      ent.pt_a        = partial;
      ent.has_b       = 1'b1;
      ent.b_term      = 1'b1;
      partial_next    = '0;
      expect_cnt_next = 2'd0;
    end else if (open_seq && in_byte[7:6] == CONT_TAG) begin
      expect_cnt_next = dec_cnt;
      if (dec_cnt == 2'd0) begin
        ent.has_b    = 1'b1;
        ent.pt_b     = merged;
        partial_next = '0;
      end else begin
        partial_next = merged;
      end
    end else begin
      // early lead flushes the open point as it stands
      ent.has_a = open_seq;
      ent.pt_a  = partial;
      if (!in_byte[7]) begin
        ent.has_b       = 1'b1;
        ent.pt_b        = {13'd0, in_byte};
        partial_next    = '0;
        expect_cnt_next = 2'd0;
      end else if (in_byte <= LEAD_2B_MAX) begin
        partial_next    = {10'd0, in_byte[4:0], 6'd0};
        expect_cnt_next = 2'd1;
      end else if (in_byte <= LEAD_3B_MAX) begin
        partial_next    = {5'd0, in_byte[3:0], 12'd0};
        expect_cnt_next = 2'd2;
      end else begin
        partial_next    = {in_byte[2:0], 18'd0};
        expect_cnt_next = 2'd3;
      end
    end
  end

  assign push       = accept && (ent.has_a || ent.has_b);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      expect_cnt <= 2'd0;
    end else if (accept) begin
      partial    <= partial_next;
      expect_cnt <= expect_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8tx_queue.sv -----
// ----------------------------------------------------------------------------
// u8tx_queue
// Small register FIFO between the byte decoder and the word emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tx_queue
  import u8tx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire u8tx_entry_t push_entry,
  input  wire logic        pop,
  output logic             full,
  output logic             head_valid,
  output u8tx_entry_t      head
);

  u8tx_entry_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/u8tx_back.sv -----
// ----------------------------------------------------------------------------
// u8tx_back
// Word emitter: expands queued events into code units, counts them and
// holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tx_back
  import u8tx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_data,
  input  wire logic                   head_valid,
  input  wire u8tx_entry_t            head,
  output logic                        pop,
  output logic                        second_half,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [UNIT_W-1:0]           code_unit,
  output logic                        is_terminator,
  output logic [COUNT_WIDTH-1:0]      unit_count
);

  logic                   mode;
  logic                   done_a;
  logic                   half;
  logic [COUNT_WIDTH-1:0] units;
  logic                   load;
  logic                   cur_is_a;
  logic [UNIT_W-1:0]      pt;
  logic                   term;
  logic                   surr;
  logic [UNIT_W-1:0]      v;
  logic [UNIT_W-1:0]      unit_next;
  logic                   event_last;
  logic                   entry_last;

  assign load     = head_valid && (!out_valid || !out_stall);
  assign cur_is_a = head.has_a && !done_a;
  assign pt       = cur_is_a ? head.pt_a : head.pt_b;
  assign term     = !cur_is_a && head.b_term;
  assign surr     = (mode == MODE_UTF16) && !term && (pt[UNIT_W-1:16] != '0);
  assign v        = pt - SUPP_BASE;

  always_comb begin
    if (term) begin
      unit_next = '0;
    end else if (surr && half) begin
      unit_next = {11'd0, v[9:0]} + LO_SURR_BASE;
    end else if (surr) begin
      unit_next = {10'd0, v[20:10]} + HI_SURR_BASE;
    end else begin
      unit_next = pt;
    end
  end

  assign event_last  = !surr || half;
  assign entry_last  = event_last && (!cur_is_a || !head.has_b);
  assign pop         = load && entry_last;
  assign second_half = half;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UTF16;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done_a    <= 1'b0;
      half      <= 1'b0;
      units     <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (entry_last) begin
          done_a <= 1'b0;
          half   <= 1'b0;
        end else if (event_last) begin
          done_a <= 1'b1;
          half   <= 1'b0;
        end else begin
          half <= 1'b1;
        end
        if (term) begin
          units <= '0;
        end else if (units != COUNT_MAX) begin
          units <= units + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_unit     <= unit_next;
      is_terminator <= term;
      unit_count    <= term ? units : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_utf32_transcoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_utf32_transcoder_core
// Lenient UTF-8 decoder that emits UTF-16 code units or UTF-32 code points.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   -----------------------------------------
//  in        in_valid / in_stall    in_byte[7:0]
//  out       out_valid / out_stall  code_unit[20:0], is_terminator,
//                                   unit_count[23:0]
//  cfg       cfg_valid / cfg_ready  cfg_data (output_mode, 0 = utf-16)
//
//  one byte is taken per cycle while the four-entry event queue has room
//  the emitter sends one word per cycle while out_stall is low, and a byte
//  can produce up to three words
//  ascii runs at one byte per cycle while out_stall is low
//  a byte is registered in a queue slot, then its first word in the output register
//  synchronous reset clears the control state but not the data registers; cfg_ready is always high
//  in_stall rises only when the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_utf32_transcoder_core
  import u8tx_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [UNIT_W-1:0]           code_unit,
  output logic                        is_terminator,
  output logic [COUNT_WIDTH-1:0]      unit_count,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data
);

  logic        q_full;
  logic        push;
  u8tx_entry_t push_entry;
  logic        pop;
  logic        head_valid;
  u8tx_entry_t head;
  logic        second_half;

  assign cfg_ready = 1'b1;

  u8tx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8tx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8tx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .second_half   (second_half),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_unit     (code_unit),
    .is_terminator (is_terminator),
    .unit_count    (unit_count)
  );

  // a stalled input always has queued work behind it
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> head_valid)
    else $error("input stalled with empty queue");

  // low surrogate pending means its entry is still at the queue head
  a_half_has_head: assert property (@(posedge clk) disable iff (rst)
    second_half |-> head_valid)
    else $error("surrogate half without queued entry");

  a_term_zero_unit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_terminator) |-> (code_unit == '0))
    else $error("terminator with nonzero code unit");

  a_count_only_term: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_terminator) |-> (unit_count == '0))
    else $error("unit count on a non-terminator word");

endmodule

`default_nettype wire
